// ===== rtl/proximity_alert_led_sequencer_top_macros.svh =====
// Assertion helpers used by pals_core.
`ifndef PROXIMITY_ALERT_LED_SEQUENCER_TOP_MACROS_SVH
`define PROXIMITY_ALERT_LED_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication
`define PALS_ASSERT_IMPL(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pals assertion failed");

// next-cycle implication
`define PALS_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pals assertion failed");

`endif

// ===== rtl/pals_pkg.sv =====
package pals_pkg;

	typedef enum logic [2:0] {
		OP_ENTRY = 3'd0,
		OP_SWEEP = 3'd1,
		OP_TICK  = 3'd2,
		OP_OFF   = 3'd3,
		OP_FETCH = 3'd4
	} op_e;

	typedef enum logic [2:0] {
		REG_VISUAL  = 3'd0,
		REG_AMBER   = 3'd1,
		REG_YELLOW  = 3'd2,
		REG_BLUE    = 3'd3,
		REG_FLASH   = 3'd4,
		REG_BRIGHT  = 3'd5
	} cfg_reg_e;

	localparam logic [23:0] COL_OFF    = 24'h000000;
	localparam logic [23:0] COL_WHITE  = 24'hFFFFFF;
	localparam logic [23:0] COL_BLUE   = 24'h0000FF;
	localparam logic [23:0] COL_YELLOW = 24'hFFFF00;
	localparam logic [23:0] COL_AMBER  = 24'hFFB000;
	localparam logic [23:0] COL_GREEN  = 24'h00FF00;

	localparam logic [31:0] BEACON_ON_MS = 32'd120;
	localparam logic [11:0] NORTH_HIGH   = 12'd3000;
	localparam logic [11:0] NORTH_LOW    = 12'd600;
	localparam logic [6:0]  PCT_MAX      = 7'd100;

	typedef struct packed {
		logic [15:0] visual_dist;
		logic [15:0] amber_dist;
		logic [15:0] yellow_dist;
		logic [15:0] blue_dist;
		logic [15:0] flash_period;
		logic [7:0]  brightness_level;
	} cfg_t;

	// pct*255/100 via reciprocal 5243/2^19, exact for pct <= 100
	function automatic logic [7:0] bright_level(input logic [6:0] pct);
		logic [27:0] prod;
		prod = 28'(pct) * 28'd255 * 28'd5243;
		return prod[26:19];
	endfunction

endpackage

// ===== rtl/pals_if.sv =====
interface pals_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic        entry_valid;
	logic [15:0] target_distance;
	logic [7:0]  entry_index;
	logic signed [8:0] chosen_index;
	logic        last_entry;
	logic [11:0] sweep_angle;
	logic [31:0] now_ms;

	modport source (
		output valid, opcode, entry_valid, target_distance, entry_index,
			chosen_index, last_entry, sweep_angle, now_ms,
		input  ready
	);
	modport sink (
		input  valid, opcode, entry_valid, target_distance, entry_index,
			chosen_index, last_entry, sweep_angle, now_ms,
		output ready
	);
endinterface

interface pals_out_if;
	logic        valid;
	logic        ready;
	logic        pixel_write;
	logic [23:0] pixel_color;
	logic [7:0]  brightness_level;
	logic        flash_rising_edge;

	modport source (
		output valid, pixel_write, pixel_color, brightness_level, flash_rising_edge,
		input  ready
	);
	modport sink (
		input  valid, pixel_write, pixel_color, brightness_level, flash_rising_edge,
		output ready
	);
endinterface

// ===== rtl/proximity_alert_led_sequencer_top.sv =====
// Proximity alert LED sequencer: turns a streamed target table, radar sweep
// angles and millisecond ticks into writes of one status LED colour. Every
// input transaction yields exactly one result transaction in the next cycle,
// and a new transaction is taken every cycle: the only stage is the result
// register, and input ready is low only while that register holds a result
// that the sink has not yet taken. Configuration writes (zone thresholds,
// flash period, brightness) take effect on the next transaction and are
// meant to be done while the block is idle.
module proximity_alert_led_sequencer_top
	import pals_pkg::*;
#(
	parameter int MAX_ENTRIES = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	pals_in_if.sink     item,
	pals_out_if.source  result
);

	cfg_t cfg;

	pals_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	pals_core #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

endmodule

// ===== rtl/pals_cfg.sv =====
module pals_cfg
	import pals_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic [2:0]  index,
	input  logic [15:0] wdata,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic [6:0] pct_sat;

	assign pct_sat = (wdata[6:0] > PCT_MAX) ? PCT_MAX : wdata[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.visual_dist      <= 16'd32;
			cfg_q.amber_dist       <= 16'd80;
			cfg_q.yellow_dist      <= 16'd160;
			cfg_q.blue_dist        <= 16'd400;
			cfg_q.flash_period     <= 16'd250;
			cfg_q.brightness_level <= bright_level(7'd90);
		end else if (we) begin
			case (cfg_reg_e'(index))
				REG_VISUAL: cfg_q.visual_dist      <= wdata;
				REG_AMBER:  cfg_q.amber_dist       <= wdata;
				REG_YELLOW: cfg_q.yellow_dist      <= wdata;
				REG_BLUE:   cfg_q.blue_dist        <= wdata;
				REG_FLASH:  cfg_q.flash_period     <= wdata;
				REG_BRIGHT: cfg_q.brightness_level <= bright_level(pct_sat);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/pals_core.sv =====
`include "proximity_alert_led_sequencer_top_macros.svh"

module pals_core
	import pals_pkg::*;
#(
	parameter int MAX_ENTRIES = 255
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	pals_in_if.sink         item,
	pals_out_if.source      result
);

	localparam logic [7:0] MaxIdx = 8'(MAX_ENTRIES);

	// state
	logic [23:0] base_color_q, base_color_n;
	logic        flash_en_q, flash_en_n;
	logic        phase_on_q, phase_on_n;
	logic [31:0] last_toggle_q, last_toggle_n;
	logic        rise_q, rise_n;
	logic        armed_q, armed_n;
	logic        active_q, active_n;
	logic [31:0] off_time_q, off_time_n;
	logic [11:0] prev_angle_q, prev_angle_n;
	logic        any_q, any_n;
	logic [15:0] nearest_q, nearest_n;
	logic        found_q, found_n;
	logic [15:0] cdist_q, cdist_n;

	// result register
	logic        out_vld_q;
	logic        write_q, write_n;
	logic [23:0] color_q, color_n;
	logic [7:0]  level_q;
	logic        edge_q;

	logic        accept;
	logic [15:0] sel_dist;
	logic [31:0] beacon_diff;
	logic [31:0] toggle_diff;
	logic        crossed;
	logic        chosen_hit;

	assign item.ready = !out_vld_q || result.ready;
	assign accept     = item.valid && item.ready;

	assign beacon_diff = item.now_ms - off_time_q;
	assign toggle_diff = item.now_ms - last_toggle_q;
	assign crossed     = (prev_angle_q > NORTH_HIGH) && (item.sweep_angle < NORTH_LOW);
	assign chosen_hit  = !item.chosen_index[8] && (item.chosen_index[7:0] == item.entry_index);

	always_comb begin
		base_color_n  = base_color_q;
		flash_en_n    = flash_en_q;
		phase_on_n    = phase_on_q;
		last_toggle_n = last_toggle_q;
		rise_n        = rise_q;
		armed_n       = armed_q;
		active_n      = active_q;
		off_time_n    = off_time_q;
		prev_angle_n  = prev_angle_q;
		any_n         = any_q;
		nearest_n     = nearest_q;
		found_n       = found_q;
		cdist_n       = cdist_q;
		write_n       = 1'b0;
		color_n       = COL_OFF;
		sel_dist      = 16'd0;

		case (op_e'(item.opcode))
			OP_ENTRY: begin
				if (item.entry_index < MaxIdx && item.entry_valid) begin
					any_n = 1'b1;
					if (item.target_distance < nearest_q)
						nearest_n = item.target_distance;
					if (chosen_hit) begin
						found_n = 1'b1;
						cdist_n = item.target_distance;
					end
				end
				if (item.last_entry) begin
					sel_dist   = found_n ? cdist_n : nearest_n;
					armed_n    = 1'b0;
					flash_en_n = 1'b0;
					if (!(any_n || found_n)) begin
						base_color_n = COL_OFF;
						armed_n      = 1'b1;
					end else if (sel_dist <= cfg.visual_dist) begin
						base_color_n = COL_GREEN;
						flash_en_n   = 1'b1;
					end else if (sel_dist <= cfg.amber_dist) begin
						base_color_n = COL_AMBER;
					end else if (sel_dist <= cfg.yellow_dist) begin
						base_color_n = COL_YELLOW;
					end else if (sel_dist <= cfg.blue_dist) begin
						base_color_n = COL_BLUE;
					end else begin
						base_color_n = COL_OFF;
						armed_n      = 1'b1;
					end
					any_n     = 1'b0;
					nearest_n = 16'hFFFF;
					found_n   = 1'b0;
					cdist_n   = 16'd0;
					if (!flash_en_n) begin
						phase_on_n = 1'b0;
						if (!armed_n || !active_q) begin
							write_n = 1'b1;
							color_n = armed_n ? COL_OFF : base_color_n;
						end
					end
				end
			end
			OP_SWEEP: begin
				prev_angle_n = item.sweep_angle;
				if (armed_q && !flash_en_q && crossed) begin
					active_n   = 1'b1;
					off_time_n = item.now_ms + BEACON_ON_MS;
					write_n    = 1'b1;
					color_n    = COL_GREEN;
				end
			end
			OP_TICK: begin
				rise_n = 1'b0;
				// wrap-safe "now at or past off time"
				if (active_q && !beacon_diff[31]) begin
					active_n = 1'b0;
					if (armed_q && !flash_en_q) begin
						write_n = 1'b1;
						color_n = COL_OFF;
					end
				end
				if (flash_en_q && toggle_diff >= {16'd0, cfg.flash_period}) begin
					last_toggle_n = item.now_ms;
					phase_on_n    = !phase_on_q;
					write_n       = 1'b1;
					color_n       = phase_on_q ? COL_OFF : base_color_q;
					rise_n        = !phase_on_q;
				end
			end
			OP_OFF: begin
				base_color_n = COL_OFF;
				flash_en_n   = 1'b0;
				phase_on_n   = 1'b0;
				armed_n      = 1'b0;
				active_n     = 1'b0;
				write_n      = 1'b1;
				color_n      = COL_OFF;
			end
			OP_FETCH: begin
				write_n = 1'b1;
				color_n = COL_WHITE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_color_q  <= COL_OFF;
			flash_en_q    <= 1'b0;
			phase_on_q    <= 1'b0;
			last_toggle_q <= 32'd0;
			rise_q        <= 1'b0;
			armed_q       <= 1'b0;
			active_q      <= 1'b0;
			off_time_q    <= 32'd0;
			prev_angle_q  <= 12'd0;
			any_q         <= 1'b0;
			nearest_q     <= 16'hFFFF;
			found_q       <= 1'b0;
			cdist_q       <= 16'd0;
		end else if (accept) begin
			base_color_q  <= base_color_n;
			flash_en_q    <= flash_en_n;
			phase_on_q    <= phase_on_n;
			last_toggle_q <= last_toggle_n;
			rise_q        <= rise_n;
			armed_q       <= armed_n;
			active_q      <= active_n;
			off_time_q    <= off_time_n;
			prev_angle_q  <= prev_angle_n;
			any_q         <= any_n;
			nearest_q     <= nearest_n;
			found_q       <= found_n;
			cdist_q       <= cdist_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			write_q <= write_n;
			color_q <= color_n;
			level_q <= cfg.brightness_level;
			edge_q  <= rise_n;
		end
	end

	assign result.valid             = out_vld_q;
	assign result.pixel_write       = write_q;
	assign result.pixel_color       = color_q;
	assign result.brightness_level  = level_q;
	assign result.flash_rising_edge = edge_q;

	`PALS_ASSERT_IMPL(a_color_idle, clk, arst_n, out_vld_q && !write_q, color_q == COL_OFF)
	`PALS_ASSERT_IMPL(a_flash_not_armed, clk, arst_n, flash_en_q, !armed_q)
	`PALS_ASSERT_IMPL(a_flash_green, clk, arst_n, flash_en_q, base_color_q == COL_GREEN)
	`PALS_ASSERT_NEXT(a_accept_result, clk, arst_n, accept, out_vld_q)

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pals_pkg::*;

	localparam int TABLE_ROWS = 255;

	// opcodes the block has no meaning for
	localparam logic [2:0] OP_SPARE_A = 3'd5;
	localparam logic [2:0] OP_SPARE_B = 3'd6;
	localparam logic [2:0] OP_SPARE_C = 3'd7;

	typedef struct packed {
		logic [2:0]        opcode;
		logic              entry_valid;
		logic [15:0]       distance;
		logic [7:0]        idx;
		logic signed [8:0] chosen;
		logic              last_mark;
		logic [11:0]       angle;
		logic [31:0]       now_ms;
	} tb_item_t;

	typedef struct packed {
		logic        write;
		logic [23:0] rgb;
		logic [7:0]  level;
		logic        rise;
	} led_out_t;

	class led_scoreboard;
		logic [15:0] visual_lim, amber_lim, yellow_lim, blue_lim, flash_ms;
		logic [6:0]  bright_pct;

		logic [23:0] base_rgb;
		bit          flashing, phase_on, edge_flag, beacon_armed, beacon_on;
		logic [31:0] toggle_ms, beacon_end_ms;
		logic [11:0] last_angle;
		bit          seen_valid, chosen_seen;
		logic [15:0] nearest, chosen_dist;

		led_out_t led_writes_due[$];
		int       errors = 0;

		function void clear_scan();
			seen_valid = 0;
			nearest = 16'hFFFF;
			chosen_seen = 0;
			chosen_dist = '0;
		endfunction

		function void clear_all();
			visual_lim = 16'd32;
			amber_lim = 16'd80;
			yellow_lim = 16'd160;
			blue_lim = 16'd400;
			flash_ms = 16'd250;
			bright_pct = 7'd90;
			base_rgb = COL_OFF;
			flashing = 0;
			phase_on = 0;
			edge_flag = 0;
			beacon_armed = 0;
			beacon_on = 0;
			toggle_ms = '0;
			beacon_end_ms = '0;
			last_angle = '0;
			clear_scan();
		endfunction

		function void set_reg(cfg_reg_e r, logic [15:0] v);
			case (r)
				REG_VISUAL: visual_lim = v;
				REG_AMBER:  amber_lim = v;
				REG_YELLOW: yellow_lim = v;
				REG_BLUE:   blue_lim = v;
				REG_FLASH:  flash_ms = v;
				REG_BRIGHT: bright_pct = (v[6:0] > PCT_MAX) ? PCT_MAX : v[6:0];
				default: ;
			endcase
		endfunction

		// end of a table update: pick the zone from chosen or nearest target
		function void close_table();
			logic [15:0] d;
			d = chosen_seen ? chosen_dist : nearest;
			beacon_armed = 0;
			flashing = 0;
			if (!(seen_valid || chosen_seen)) begin
				base_rgb = COL_OFF;
				beacon_armed = 1;
			end else if (d <= visual_lim) begin
				base_rgb = COL_GREEN;
				flashing = 1;
			end else if (d <= amber_lim) begin
				base_rgb = COL_AMBER;
			end else if (d <= yellow_lim) begin
				base_rgb = COL_YELLOW;
			end else if (d <= blue_lim) begin
				base_rgb = COL_BLUE;
			end else begin
				base_rgb = COL_OFF;
				beacon_armed = 1;
			end
			clear_scan();
		endfunction

		function void predict_led_write(tb_item_t it);
			led_out_t    due;
			logic [23:0] rgb;
			bit          wr, crossed;
			logic [31:0] delta;
			wr = 0;
			rgb = COL_OFF;
			case (it.opcode)
				OP_ENTRY: begin
					if (it.idx < TABLE_ROWS && it.entry_valid) begin
						seen_valid = 1;
						if (it.distance < nearest)
							nearest = it.distance;
						if (!it.chosen[8] && it.chosen[7:0] == it.idx) begin
							chosen_seen = 1;
							chosen_dist = it.distance;
						end
					end
					if (it.last_mark) begin
						close_table();
						if (!flashing) begin
							phase_on = 0;
							if (!beacon_armed || !beacon_on) begin
								wr = 1;
								rgb = beacon_armed ? COL_OFF : base_rgb;
							end
						end
					end
				end
				OP_SWEEP: begin
					crossed = last_angle > NORTH_HIGH && it.angle < NORTH_LOW;
					last_angle = it.angle;
					if (beacon_armed && !flashing && crossed) begin
						beacon_on = 1;
						beacon_end_ms = it.now_ms + BEACON_ON_MS;
						wr = 1;
						rgb = COL_GREEN;
					end
				end
				OP_TICK: begin
					edge_flag = 0;
					// wrapping compare: a difference below 2^31 means reached
					delta = it.now_ms - beacon_end_ms;
					if (beacon_on && !delta[31]) begin
						beacon_on = 0;
						if (beacon_armed && !flashing) begin
							wr = 1;
							rgb = COL_OFF;
						end
					end
					delta = it.now_ms - toggle_ms;
					if (flashing && delta >= {16'b0, flash_ms}) begin
						toggle_ms = it.now_ms;
						phase_on = !phase_on;
						wr = 1;
						rgb = phase_on ? base_rgb : COL_OFF;
						if (phase_on)
							edge_flag = 1;
					end
				end
				OP_OFF: begin
					base_rgb = COL_OFF;
					flashing = 0;
					phase_on = 0;
					beacon_armed = 0;
					beacon_on = 0;
					wr = 1;
					rgb = COL_OFF;
				end
				OP_FETCH: begin
					wr = 1;
					rgb = COL_WHITE;
				end
				default: ;
			endcase
			due.write = wr;
			due.rgb = wr ? rgb : COL_OFF;
			due.level = 8'((int'(bright_pct) * 255) / 100);
			due.rise = edge_flag;
			led_writes_due.push_back(due);
		endfunction

		function void report(string what, logic [31:0] want, logic [31:0] got);
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
			errors++;
		endfunction

		function void check_led_write(led_out_t got);
			led_out_t want;
			if (led_writes_due.size() == 0) begin
				$display("%0t: unexpected result transaction: expected none, actual %p",
					$time, got);
				errors++;
				return;
			end
			want = led_writes_due.pop_front();
			if (got.write !== want.write)
				report("pixel_write", 32'(want.write), 32'(got.write));
			if (got.rgb !== want.rgb)
				report("pixel_color", 32'(want.rgb), 32'(got.rgb));
			if (got.level !== want.level)
				report("brightness_level", 32'(want.level), 32'(got.level));
			if (got.rise !== want.rise)
				report("flash_rising_edge", 32'(want.rise), 32'(got.rise));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_wdata;

	pals_in_if  in_ch();
	pals_out_if out_ch();

	proximity_alert_led_sequencer_top #(
		.MAX_ENTRIES(TABLE_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item(in_ch),
		.result(out_ch)
	);

	always #6 clk = ~clk;

	led_scoreboard board;
	bit            steady = 0;
	int            sent_count = 0;
	int            results_taken = 0;
	logic [31:0]   ms_now = '0;
	int            sweep_pos = 0;

	task automatic put_fields(input tb_item_t it);
		in_ch.opcode <= it.opcode;
		in_ch.entry_valid <= it.entry_valid;
		in_ch.target_distance <= it.distance;
		in_ch.entry_index <= it.idx;
		in_ch.chosen_index <= it.chosen;
		in_ch.last_entry <= it.last_mark;
		in_ch.sweep_angle <= it.angle;
		in_ch.now_ms <= it.now_ms;
	endtask

	task automatic send_item(input tb_item_t it);
		while (!steady && $urandom_range(0, 99) < 33) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		put_fields(it);
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		board.predict_led_write(it);
		if (it.opcode <= OP_FETCH)
			sent_count++;
	endtask

	task automatic write_reg(input cfg_reg_e r, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
		board.set_reg(r, v);
	endtask

	task automatic load_settings(input logic [15:0] vis, amb, yel, blu, per, pct);
		write_reg(REG_VISUAL, vis);
		write_reg(REG_AMBER, amb);
		write_reg(REG_YELLOW, yel);
		write_reg(REG_BLUE, blu);
		write_reg(REG_FLASH, per);
		write_reg(REG_BRIGHT, pct);
		cfg_we <= 1'b0;
	endtask

	// wait until every expected result has been taken, or count the missing ones as errors
	task automatic settle();
		int waited;
		waited = 0;
		in_ch.valid <= 1'b0;
		while (board.led_writes_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (board.led_writes_due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				board.led_writes_due.size());
			board.errors += board.led_writes_due.size();
			board.led_writes_due.delete();
		end
	endtask

	function automatic tb_item_t random_fields();
		tb_item_t it;
		it.opcode = 3'($urandom_range(0, 7));
		it.entry_valid = 1'($urandom);
		it.distance = 16'($urandom);
		it.idx = 8'($urandom);
		it.chosen = 9'($urandom);
		it.last_mark = 1'($urandom);
		it.angle = 12'($urandom);
		it.now_ms = $urandom;
		return it;
	endfunction

	function automatic tb_item_t entry(input bit v, input logic [15:0] d,
			input logic [7:0] i, input logic signed [8:0] c, input bit l);
		tb_item_t it;
		it = random_fields();
		it.opcode = OP_ENTRY;
		it.entry_valid = v;
		it.distance = d;
		it.idx = i;
		it.chosen = c;
		it.last_mark = l;
		return it;
	endfunction

	function automatic tb_item_t timed(input logic [2:0] op, input logic [11:0] a,
			input logic [31:0] t);
		tb_item_t it;
		it = random_fields();
		it.opcode = op;
		it.angle = a;
		it.now_ms = t;
		return it;
	endfunction

	function automatic logic [15:0] pick_distance();
		logic [15:0] d;
		case ($urandom_range(0, 4))
			0: d = 16'($urandom);
			1, 2: d = 16'($urandom_range(0, 450));
			3: begin
				case ($urandom_range(0, 3))
					0: d = board.visual_lim;
					1: d = board.amber_lim;
					2: d = board.yellow_lim;
					default: d = board.blue_lim;
				endcase
				d = d + 16'($urandom_range(0, 2)) - 16'd1;
			end
			default: d = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
		endcase
		return d;
	endfunction

	task automatic directed_items();
		send_item(timed(OP_FETCH, 12'd0, 32'd0));
		send_item(timed(OP_SPARE_A, 12'd0, 32'd0));
		send_item(timed(OP_SPARE_B, 12'd0, 32'd0));
		send_item(timed(OP_SPARE_C, 12'd0, 32'd0));
		// empty table arms the beacon
		send_item(entry(1'b0, 16'd0, 8'd0, -9'sd1, 1'b1));
		send_item(timed(OP_SWEEP, 12'd3599, 32'hFFFF_FFF0));
		send_item(timed(OP_SWEEP, 12'd0, 32'hFFFF_FFF8));
		// beacon end time wrapped past zero
		send_item(timed(OP_TICK, 12'd0, 32'h0000_0010));
		send_item(timed(OP_TICK, 12'd0, 32'h0000_0070));
		send_item(timed(OP_SWEEP, 12'hFFF, 32'h0000_0100));
		send_item(timed(OP_SWEEP, 12'd599, 32'h0000_0110));
		send_item(timed(OP_OFF, 12'd0, 32'd0));
		// chosen entry repeated, last one wins; row 255 ignored
		send_item(entry(1'b1, 16'd100, 8'd3, 9'sd3, 1'b0));
		send_item(entry(1'b1, 16'd20, 8'd3, 9'sd3, 1'b0));
		send_item(entry(1'b1, 16'd0, 8'd5, 9'sd3, 1'b0));
		send_item(entry(1'b1, 16'd0, 8'd255, 9'sd3, 1'b0));
		send_item(entry(1'b0, 16'hFFFF, 8'd7, 9'sd3, 1'b1));
		send_item(timed(OP_TICK, 12'd0, 32'd250));
		send_item(timed(OP_TICK, 12'd0, 32'd300));
		send_item(timed(OP_TICK, 12'd0, 32'd500));
		send_item(entry(1'b1, 16'hFFFF, 8'd0, -9'sd256, 1'b0));
		send_item(entry(1'b1, 16'd401, 8'd254, 9'sd255, 1'b0));
		// ignored row still closes the update
		send_item(entry(1'b1, 16'd0, 8'd255, -9'sd1, 1'b1));
		send_item(entry(1'b1, 16'd80, 8'd1, 9'sd1, 1'b1));
		send_item(timed(OP_TICK, 12'd0, 32'hFFFF_FFFF));
	endtask

	task automatic random_table();
		int                rows;
		logic signed [8:0] pick;
		tb_item_t          it;
		rows = $urandom_range(0, 6);
		if ($urandom_range(0, 2) == 0)
			pick = 9'($urandom_range(256, 511));
		else
			pick = 9'($urandom_range(0, rows + 1));
		if (rows == 0) begin
			send_item(entry(1'b0, pick_distance(), 8'($urandom), pick, 1'b1));
		end else begin
			for (int k = 0; k < rows; k++) begin
				it = entry($urandom_range(0, 9) < 8, pick_distance(), 8'(k), pick,
					k == rows - 1);
				case ($urandom_range(0, 11))
					0: it.idx = pick[7:0];
					1: it.idx = 8'hFF;
					default: ;
				endcase
				send_item(it);
			end
		end
	endtask

	task automatic random_sweeps();
		logic [11:0] a;
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(0, 9) == 0) begin
				a = 12'($urandom);
				sweep_pos = a % 3600;
			end else begin
				sweep_pos = (sweep_pos + $urandom_range(100, 700)) % 3600;
				a = 12'(sweep_pos);
			end
			ms_now = ms_now + $urandom_range(5, 120);
			send_item(timed(OP_SWEEP, a, ms_now));
		end
	endtask

	task automatic random_ticks();
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 19))
				0: ms_now = ms_now + $urandom;
				1: ms_now = ms_now - $urandom_range(1, 50);
				default: ms_now = ms_now + $urandom_range(0, 2 * int'(board.flash_ms) + 50);
			endcase
			send_item(timed(OP_TICK, 12'($urandom), ms_now));
		end
	endtask

	task automatic random_traffic(input int goal);
		int start;
		start = sent_count;
		while (sent_count - start < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: random_table();
				4, 5: random_sweeps();
				6, 7: random_ticks();
				8: send_item(timed($urandom_range(0, 1) ? OP_OFF : OP_FETCH, 12'd0, ms_now));
				default: send_item(random_fields());
			endcase
		end
	endtask

	initial begin : stimulus
		logic [15:0] a, b, c, d;
		board = new();
		board.clear_all();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_VISUAL;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		put_fields('0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_items();
		settle();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
				2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h007F);
				3, 4: begin
					a = 16'($urandom_range(0, 100));
					b = a + 16'($urandom_range(0, 100));
					c = b + 16'($urandom_range(0, 200));
					d = c + 16'($urandom_range(0, 300));
					load_settings(a, b, c, d, 16'($urandom_range(1, 300)),
						16'($urandom_range(0, 100)));
				end
				5: load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(1, 400)), 16'($urandom));
				default: ;
			endcase
			// one whole phase with no idle cycles on either side
			steady = (phase == 4);
			random_traffic(105);
			settle();
		end
		steady = 0;
		repeat (4) @(posedge clk);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : led_sink
		int       stall_left;
		bit       held;
		led_out_t seen;
		stall_left = 0;
		held = 0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				seen.write = out_ch.pixel_write;
				seen.rgb = out_ch.pixel_color;
				seen.level = out_ch.brightness_level;
				seen.rise = out_ch.flash_rising_edge;
				board.check_led_write(seen);
				results_taken++;
			end
			// long hold-off so the input side backs up
			if (!held && results_taken >= 200) begin
				held = 1;
				stall_left = 64;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= steady || $urandom_range(0, 99) >= 33;
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
